FILE: rtl/core/key_value_line_parser_assert.svh
// assertion macros shared by the parser rtl
`ifndef KEY_VALUE_LINE_PARSER_ASSERT_SVH
`define KEY_VALUE_LINE_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
`define KVLP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KVLP_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define KVLP_ASSERT(lbl, prop, msg)
`define KVLP_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: rtl/core/kvlp_pkg.sv
// types and constants of the key/value line parser
package kvlp_pkg;

    localparam int MAX_FIELD = 4096;
    localparam int LEN_W     = 13;
    localparam int POS_W     = 12;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
    localparam int OUT_DW    = 40;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef enum logic [2:0] {
        K_NAME_BYTE  = 3'd0,
        K_VALUE_BYTE = 3'd1,
        K_NAME_END   = 3'd2,
        K_RECORD_END = 3'd3,
        K_OK         = 3'd4,
        K_ERROR      = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ERR_COMMENT    = 2'd0,
        ERR_TOO_LONG   = 2'd1,
        ERR_INCOMPLETE = 2'd2
    } err_t;

    // what the end of stream adds after the byte's own beat
    typedef enum logic [1:0] {
        TAIL_NONE   = 2'd0,
        TAIL_OK     = 2'd1,
        TAIL_INCOMP = 2'd2,
        TAIL_REC_OK = 2'd3
    } tail_t;

    typedef enum logic [6:0] {
        PH_START      = 7'b0000001,
        PH_NAME_LEAD  = 7'b0000010,
        PH_NAME       = 7'b0000100,
        PH_VALUE_LEAD = 7'b0001000,
        PH_VALUE      = 7'b0010000,
        PH_COMMENT    = 7'b0100000,
        PH_ERROR      = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic              has_first;
        kind_t             kind;
        logic [7:0]        text_byte;
        logic [POS_W-1:0]  position;
        logic [LEN_W-1:0]  trim;
        err_t              err;
        tail_t             tail;
        logic [LEN_W-1:0]  tail_trim;
    } entry_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

endpackage

FILE: rtl/core/kvlp_front.sv
// front end: classifies each byte, updates the parse state, builds a queue entry
module kvlp_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [7:0]     in_byte,
    input  logic           in_eos,
    input  logic           q_full,
    output logic           in_ready,
    output logic           push,
    output kvlp_pkg::entry_t push_entry
);
    import kvlp_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] trim_reg, trim_next;
    entry_t           ent;
    logic             accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        logic   blank;
        logic   do_store;
        logic   do_fail;
        kind_t  store_kind;
        phase_t store_phase;
        err_t   fail_code;

        blank       = (in_byte == CH_SP) || (in_byte == CH_TAB);
        do_store    = 1'b0;
        do_fail     = 1'b0;
        store_kind  = K_NAME_BYTE;
        store_phase = PH_NAME;
        fail_code   = ERR_COMMENT;
        phase_next  = phase_reg;
        len_next    = len_reg;
        trim_next   = trim_reg;
        ent         = '0;
        ent.kind    = K_OK;
        ent.err     = ERR_COMMENT;
        ent.tail    = TAIL_NONE;

        unique case (phase_reg)
            PH_START, PH_NAME_LEAD, PH_NAME:
            begin
                if (phase_reg == PH_START && in_byte == CH_NL)
                begin
                    // blank line
                end
                else if (in_byte == CH_COLON)
                begin
                    ent.has_first = 1'b1;
                    ent.kind      = K_NAME_END;
                    ent.trim      = trim_reg;
                    phase_next    = PH_VALUE_LEAD;
                    len_next      = '0;
                    trim_next     = '0;
                end
                else if (in_byte == CH_HASH)
                begin
                    if (len_reg != '0)
                    begin
                        do_fail   = 1'b1;
                        fail_code = ERR_COMMENT;
                    end
                    else
                    begin
                        phase_next = PH_COMMENT;
                    end
                end
                else if (len_reg == '0 && blank)
                begin
                    phase_next = PH_NAME_LEAD;
                end
                else
                begin
                    do_store    = 1'b1;
                    store_kind  = K_NAME_BYTE;
                    store_phase = PH_NAME;
                end
            end
            PH_VALUE_LEAD, PH_VALUE:
            begin
                if (in_byte == CH_NL)
                begin
                    ent.has_first = 1'b1;
                    ent.kind      = K_RECORD_END;
                    ent.trim      = trim_reg;
                    phase_next    = PH_START;
                    len_next      = '0;
                    trim_next     = '0;
                end
                else if (in_byte == CH_HASH)
                begin
                    if (len_reg == '0)
                    begin
                        do_fail   = 1'b1;
                        fail_code = ERR_COMMENT;
                    end
                    else
                    begin
                        ent.has_first = 1'b1;
                        ent.kind      = K_RECORD_END;
                        ent.trim      = trim_reg;
                        phase_next    = PH_COMMENT;
                        len_next      = '0;
                        trim_next     = '0;
                    end
                end
                else if (len_reg == '0 && blank)
                begin
                    phase_next = PH_VALUE_LEAD;
                end
                else
                begin
                    do_store    = 1'b1;
                    store_kind  = K_VALUE_BYTE;
                    store_phase = PH_VALUE;
                end
            end
            PH_COMMENT:
            begin
                if (in_byte == CH_NL)
                    phase_next = PH_START;
            end
            PH_ERROR:
            begin
                phase_next = PH_ERROR;
            end
            default:
            begin
                phase_next = PH_ERROR;
            end
        endcase

        if (do_store)
        begin
            if (len_reg >= LEN_W'(MAX_FIELD))
            begin
                do_fail   = 1'b1;
                fail_code = ERR_TOO_LONG;
            end
            else
            begin
                ent.has_first = 1'b1;
                ent.kind      = store_kind;
                ent.text_byte = in_byte;
                ent.position  = len_reg[POS_W-1:0];
                len_next      = len_reg + LEN_W'(1);
                if (!blank)
                    trim_next = len_reg + LEN_W'(1);
                phase_next    = store_phase;
            end
        end

        if (do_fail)
        begin
            ent.has_first = 1'b1;
            ent.kind      = K_ERROR;
            ent.err       = fail_code;
            phase_next    = PH_ERROR;
            len_next      = '0;
            trim_next     = '0;
        end

        if (in_eos)
        begin
            unique case (phase_next)
                PH_START, PH_NAME_LEAD, PH_COMMENT: ent.tail = TAIL_OK;
                PH_NAME, PH_VALUE_LEAD:             ent.tail = TAIL_INCOMP;
                PH_VALUE:
                begin
                    ent.tail      = TAIL_REC_OK;
                    ent.tail_trim = trim_next;
                end
                default:                            ent.tail = TAIL_NONE;
            endcase
            phase_next = PH_START;
            len_next   = '0;
            trim_next  = '0;
        end
    end

    assign push       = accept && (ent.has_first || ent.tail != TAIL_NONE);
    assign push_entry = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            len_reg   <= '0;
            trim_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            trim_reg  <= trim_next;
        end
    end

`include "key_value_line_parser_assert.svh"

    `KVLP_ASSERT(a_trim_le_len, trim_reg <= len_reg, "trimmed length exceeds field length")
    `KVLP_ASSERT(a_len_limit, len_reg <= LEN_W'(MAX_FIELD), "field length beyond limit")
    `KVLP_ASSERT_NEVER(a_err_silent, push && phase_reg == PH_ERROR, "beat queued while in error")

endmodule

FILE: rtl/core/kvlp_queue.sv
// short fifo of classified entries between front and back
module kvlp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  kvlp_pkg::entry_t  din,
    input  logic              pop,
    output kvlp_pkg::entry_t  dout,
    output kvlp_pkg::q_stat_t stat
);
    import kvlp_pkg::*;

    entry_t             mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign stat.valid = (cnt_reg != '0);
    assign stat.full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && stat.valid;
    assign dout       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + Q_CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

`include "key_value_line_parser_assert.svh"

    `KVLP_ASSERT(a_cnt_range, cnt_reg <= Q_CNT_W'(Q_DEPTH), "queue count beyond depth")
    `KVLP_ASSERT_NEVER(a_push_full, push && stat.full, "push into full queue")

endmodule

FILE: rtl/core/kvlp_back.sv
// back end: expands each queue entry into one to three output beats
module kvlp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kvlp_pkg::entry_t              head,
    input  kvlp_pkg::q_stat_t             stat,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [kvlp_pkg::OUT_DW-1:0]   out_data,
    output logic [2:0]                    out_kind,
    output logic                          out_last
);
    import kvlp_pkg::*;

    logic [1:0]       step_reg;
    logic [1:0]       beat_cnt;
    logic             load;
    logic             entry_done;
    kind_t            b_kind;
    logic [7:0]       b_byte;
    logic [POS_W-1:0] b_pos;
    logic [LEN_W-1:0] b_trim;
    err_t             b_err;

    logic             valid_reg;
    kind_t            kind_reg;
    logic [7:0]       byte_reg;
    logic [POS_W-1:0] pos_reg;
    logic [LEN_W-1:0] trim_reg;
    err_t             err_reg;
    logic             last_reg;

    always_comb
    begin
        logic [1:0] tail_len;
        logic [1:0] j;

        unique case (head.tail)
            TAIL_NONE:              tail_len = 2'd0;
            TAIL_OK, TAIL_INCOMP:   tail_len = 2'd1;
            TAIL_REC_OK:            tail_len = 2'd2;
            default:                tail_len = 2'd0;
        endcase
        beat_cnt = tail_len + {1'b0, head.has_first};
        j        = step_reg - {1'b0, head.has_first};

        b_kind = K_OK;
        b_byte = '0;
        b_pos  = '0;
        b_trim = '0;
        b_err  = ERR_COMMENT;
        if (head.has_first && step_reg == 2'd0)
        begin
            b_kind = head.kind;
            b_byte = head.text_byte;
            b_pos  = head.position;
            b_trim = head.trim;
            b_err  = head.err;
        end
        else
        begin
            unique case (head.tail)
                TAIL_INCOMP:
                begin
                    b_kind = K_ERROR;
                    b_err  = ERR_INCOMPLETE;
                end
                TAIL_REC_OK:
                begin
                    if (j == 2'd0)
                    begin
                        b_kind = K_RECORD_END;
                        b_trim = head.tail_trim;
                    end
                end
                default:
                begin
                    b_kind = K_OK;
                end
            endcase
        end
    end

    assign load       = stat.valid && (!valid_reg || out_ready);
    assign entry_done = (step_reg == beat_cnt - 2'd1);
    assign pop        = load && entry_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                step_reg  <= entry_done ? 2'd0 : step_reg + 2'd1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= b_kind;
            byte_reg <= b_byte;
            pos_reg  <= b_pos;
            trim_reg <= b_trim;
            err_reg  <= b_err;
            last_reg <= entry_done;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_last  = last_reg;
    assign out_data  = {5'b0, err_reg, trim_reg, pos_reg, byte_reg};

`include "key_value_line_parser_assert.svh"

    `KVLP_ASSERT(a_step_range, stat.valid |-> (step_reg < beat_cnt), "beat step past entry")
    `KVLP_ASSERT(a_step_idle, !stat.valid |-> (step_reg == 2'd0), "step left over with empty queue")

endmodule

FILE: rtl/core/key_value_line_parser.sv
// top level of the key/value line parser
//
//  channel | dir | beat contents
//  s_*     | in  | tdata[7:0] data_byte, tlast end_of_stream
//  m_*     | out | tuser kind, tdata text_byte/position/trimmed_length/error_code,
//          |     | tlast last_result
//
// one input byte per cycle enters the front stage while s_tready is high; the front state
// is registered on each accepted byte. each byte gives zero to three output beats, sent
// one per cycle from a 4-entry queue while m_tready is high, so the output port sets the
// rate when bytes produce more than one beat. an input beat passes the queue entry, then
// the output register. reset clears parse state, queue and output valid; no clearing
// pass. s_tready drops only while the queue is full; m_tready low holds the output register
module key_value_line_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] text_byte, [19:8] position,
                                   // [32:20] trimmed_length, [34:33] error_code
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast
);
    import kvlp_pkg::*;

    logic    push, pop;
    entry_t  push_entry, head;
    q_stat_t stat;

    kvlp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_eos     (s_tlast),
        .q_full     (stat.full),
        .in_ready   (s_tready),
        .push       (push),
        .push_entry (push_entry)
    );

    kvlp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_entry),
        .pop   (pop),
        .dout  (head),
        .stat  (stat)
    );

    kvlp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .stat      (stat),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_kind  (m_tuser),
        .out_last  (m_tlast)
    );

endmodule
